// ----- sv/kabf_pkg.sv -----
// shared types, constants and helper functions for the angle and bias kalman filter
package kabf_pkg;

    localparam int DT_FRAC  = 20;
    localparam int COV_FRAC = 24;
    localparam int REG_W    = 25;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W   = 68;
    localparam int OPA_W    = 35;
    localparam int OPB_W    = 33;
    localparam int QUOT_W   = COV_FRAC + 32;

    localparam logic [REG_W-1:0] QA_RESET =
        REG_W'(((64'd1 << COV_FRAC) + 64'd500) / 64'd1000);
    localparam logic [REG_W-1:0] QB_RESET =
        REG_W'(((64'd3 << COV_FRAC) + 64'd500) / 64'd1000);
    localparam logic [REG_W-1:0] RM_RESET =
        REG_W'(((64'd30 << COV_FRAC) + 64'd500) / 64'd1000);

    localparam logic signed [PROD_W-1:0] HALF_DT  = PROD_W'(1) <<< (DT_FRAC - 1);
    localparam logic signed [PROD_W-1:0] HALF_COV = PROD_W'(1) <<< (COV_FRAC - 1);
    localparam logic signed [69:0] S32_MAX = 70'sd2147483647;
    localparam logic signed [69:0] S32_MIN = -70'sd2147483648;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_Q = 2'd0,
        CFG_BIAS_Q  = 2'd1,
        CFG_MEAS_R  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [24:0] measured_angle;
        logic signed [27:0] gyro_rate;
        logic        [20:0] time_step;
    } t_in;

    typedef struct packed {
        logic signed [31:0] filtered_angle;
        logic signed [31:0] bias_estimate;
        logic signed [31:0] unbiased_rate;
    } t_out;

    typedef enum logic [3:0] {
        M_NONE, M_DT_RATE, M_DT_BB, M_QB_DT, M_DT_INNER,
        M_K0_Y, M_K1_Y, M_K0_P00, M_K0_P01, M_K1_P00, M_K1_P01
    } t_mul;

    typedef enum logic [3:0] {
        W_NONE, W_ANGLE_DT, W_T1, W_BB_Q, W_AA_PRED,
        W_ANGLE_K, W_BIAS_K, W_AA_K, W_AB_K, W_BA_K, W_BB_K
    } t_wb;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RATE, ST_BB, ST_QB, ST_INNER, ST_AA,
        ST_DIV0_GO, ST_DIV0_WAIT, ST_DIV1_GO, ST_DIV1_WAIT,
        ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6, ST_C7, ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        t_mul mul;
        t_wb  wb;
        logic div_start;
        logic div_num_ba;
        logic corr_latch;
        logic k0_latch;
        logic k1_latch;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_stat;

    function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
        if (v > S32_MAX) begin
            return 32'sh7fffffff;
        end else if (v < S32_MIN) begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

    function automatic logic signed [PROD_W-1:0] rnd_shift(
        input logic signed [PROD_W-1:0] p,
        input logic                     cov
    );
        logic signed [PROD_W-1:0] t;
        t = p + (cov ? HALF_COV : HALF_DT);
        return cov ? (t >>> COV_FRAC) : (t >>> DT_FRAC);
    endfunction

endpackage

// ----- sv/kalman_angle_bias_filter_unit.sv -----
// top level of the two-state angle and gyro bias kalman filter
// usage:
//   input channel carries one sample word: measured angle, gyro rate and time step
//   output channel returns one word per sample: filtered angle, bias estimate and
//   the gyro rate with the previous bias removed
//   noise registers are written through the plain write port; the user must write
//   them only while the block is idle, which the block itself does not enforce
// sample handling:
//   one sample at a time; each sample runs the two 56-step gain divides (one
//   quotient bit per cycle) and ten passes through the shared multiplier; a new
//   sample is taken only once the previous one has reached the output register
// reset:
//   angle, bias and covariance clear to zero and the noise registers return to
//   0.001, 0.003 and 0.03; the output register comes up empty
// receiver stall:
//   the finished word waits in the output register; the next sample is still
//   accepted and processed, and only its final hand-over waits for the register
module kalman_angle_bias_filter_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  kabf_pkg::t_in                  i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output kabf_pkg::t_out                 o_out_data,
    input  logic                           i_cfg_we,
    input  logic [kabf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kabf_pkg::REG_W-1:0]     i_cfg_data
);
    kabf_pkg::t_cmd  cmd;
    kabf_pkg::t_stat stat;

    kabf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    kabf_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

endmodule

// ----- sv/kabf_div.sv -----
// sequential restoring divider for the kalman gains, one quotient bit per cycle
module kabf_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic signed [33:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quot
);
    localparam int QW = kabf_pkg::QUOT_W;
    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0] r_q;
    logic [32:0]   r_rem;
    logic [32:0]   r_den;
    logic          r_neg;
    logic          r_zero;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [33:0] rem_sh;
    logic [33:0] diff;
    logic        ge;
    logic [31:0] mag;

    assign rem_sh = {r_rem, r_q[QW-1]};
    assign diff   = rem_sh - {1'b0, r_den};
    assign ge     = (rem_sh >= {1'b0, r_den});
    assign mag    = i_num[31] ? (~i_num + 32'd1) : i_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= {mag, {kabf_pkg::COV_FRAC{1'b0}}};
            r_rem  <= '0;
            r_den  <= i_den[32:0];
            r_neg  <= i_num[31];
            r_zero <= i_den[33] || (i_den == '0);
        end else if (r_busy) begin
            r_rem <= ge ? diff[32:0] : rem_sh[32:0];
            r_q   <= {r_q[QW-2:0], ge};
        end
    end

    always_comb begin
        if (r_zero) begin
            o_quot = '0;
        end else if (r_neg) begin
            if ((|r_q[QW-1:32]) || (r_q[31] && (|r_q[30:0]))) begin
                o_quot = 32'sh80000000;
            end else begin
                o_quot = -$signed(r_q[31:0]);
            end
        end else begin
            if (|r_q[QW-1:31]) begin
                o_quot = 32'sh7fffffff;
            end else begin
                o_quot = $signed(r_q[31:0]);
            end
        end
    end

    assign o_done = r_done;

endmodule

// ----- sv/kabf_dp.sv -----
// datapath: filter state, noise registers, shared multiplier and gain divider
module kabf_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  kabf_pkg::t_cmd                     i_cmd,
    output kabf_pkg::t_stat                    o_stat,
    input  kabf_pkg::t_in                      i_in_data,
    output kabf_pkg::t_out                     o_out_data,
    input  logic                               i_cfg_we,
    input  logic [kabf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [kabf_pkg::REG_W-1:0]         i_cfg_data
);
    localparam int PW = kabf_pkg::PROD_W;

    logic [kabf_pkg::REG_W-1:0] r_qa, r_qb, r_rm;
    logic signed [31:0] r_angle, r_bias, r_aa, r_ab, r_ba, r_bb;
    logic signed [24:0] r_meas;
    logic        [20:0] r_dt;
    logic signed [31:0] r_rate;
    logic signed [33:0] r_t1;
    logic signed [32:0] r_y;
    logic signed [31:0] r_p00, r_p01, r_k0, r_k1;
    logic signed [PW-1:0] r_prod;
    kabf_pkg::t_out r_out;

    logic signed [kabf_pkg::OPA_W-1:0] ma;
    logic signed [kabf_pkg::OPB_W-1:0] mb;
    logic signed [35:0] inner;
    logic signed [33:0] s_var;
    logic signed [31:0] div_num;
    logic signed [31:0] div_q;
    logic               div_done;
    logic               rnd_cov;
    logic signed [PW-1:0] rp;

    assign inner = 36'(r_t1) - 36'(r_ab) - 36'(r_ba) + $signed(36'(r_qa));
    assign s_var = 34'(r_aa) + $signed(34'(r_rm));
    assign div_num = i_cmd.div_num_ba ? r_ba : r_aa;

    always_comb begin
        ma = '0;
        mb = $signed(33'(r_dt));
        case (i_cmd.mul)
            kabf_pkg::M_DT_RATE:  ma = 35'(r_rate);
            kabf_pkg::M_DT_BB:    ma = 35'(r_bb);
            kabf_pkg::M_QB_DT:    ma = $signed(35'(r_qb));
            kabf_pkg::M_DT_INNER: ma = 35'(inner);
            kabf_pkg::M_K0_Y: begin
                ma = 35'(r_y);
                mb = 33'(r_k0);
            end
            kabf_pkg::M_K1_Y: begin
                ma = 35'(r_y);
                mb = 33'(r_k1);
            end
            kabf_pkg::M_K0_P00: begin
                ma = 35'(r_p00);
                mb = 33'(r_k0);
            end
            kabf_pkg::M_K0_P01: begin
                ma = 35'(r_p01);
                mb = 33'(r_k0);
            end
            kabf_pkg::M_K1_P00: begin
                ma = 35'(r_p00);
                mb = 33'(r_k1);
            end
            kabf_pkg::M_K1_P01: begin
                ma = 35'(r_p01);
                mb = 33'(r_k1);
            end
            default: ma = '0;
        endcase
    end

    always_comb begin
        rnd_cov = i_cmd.wb inside {kabf_pkg::W_ANGLE_K, kabf_pkg::W_BIAS_K, kabf_pkg::W_AA_K,
                                   kabf_pkg::W_AB_K, kabf_pkg::W_BA_K, kabf_pkg::W_BB_K};
        rp = kabf_pkg::rnd_shift(r_prod, rnd_cov);
    end

    kabf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (s_var),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa    <= kabf_pkg::QA_RESET;
            r_qb    <= kabf_pkg::QB_RESET;
            r_rm    <= kabf_pkg::RM_RESET;
            r_angle <= '0;
            r_bias  <= '0;
            r_aa    <= '0;
            r_ab    <= '0;
            r_ba    <= '0;
            r_bb    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    kabf_pkg::CFG_ANGLE_Q: r_qa <= i_cfg_data;
                    kabf_pkg::CFG_BIAS_Q:  r_qb <= i_cfg_data;
                    kabf_pkg::CFG_MEAS_R:  r_rm <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.mul == kabf_pkg::M_DT_INNER) begin
                r_ab <= kabf_pkg::sat32(70'(r_ab) - 70'(r_t1));
                r_ba <= kabf_pkg::sat32(70'(r_ba) - 70'(r_t1));
            end
            case (i_cmd.wb)
                kabf_pkg::W_ANGLE_DT: r_angle <= kabf_pkg::sat32(70'(r_angle) + 70'(rp));
                kabf_pkg::W_BB_Q:     r_bb    <= kabf_pkg::sat32(70'(r_bb) + 70'(rp));
                kabf_pkg::W_AA_PRED:  r_aa    <= kabf_pkg::sat32(70'(r_aa) + 70'(rp));
                kabf_pkg::W_ANGLE_K:  r_angle <= kabf_pkg::sat32(70'(r_angle) + 70'(rp));
                kabf_pkg::W_BIAS_K:   r_bias  <= kabf_pkg::sat32(70'(r_bias) + 70'(rp));
                kabf_pkg::W_AA_K:     r_aa    <= kabf_pkg::sat32(70'(r_aa) - 70'(rp));
                kabf_pkg::W_AB_K:     r_ab    <= kabf_pkg::sat32(70'(r_ab) - 70'(rp));
                kabf_pkg::W_BA_K:     r_ba    <= kabf_pkg::sat32(70'(r_ba) - 70'(rp));
                kabf_pkg::W_BB_K:     r_bb    <= kabf_pkg::sat32(70'(r_bb) - 70'(rp));
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_meas <= i_in_data.measured_angle;
            r_dt   <= i_in_data.time_step;
            r_rate <= kabf_pkg::sat32(70'(i_in_data.gyro_rate) - 70'(r_bias));
        end
        if (i_cmd.mul != kabf_pkg::M_NONE) begin
            r_prod <= ma * mb;
        end
        if (i_cmd.wb == kabf_pkg::W_T1) begin
            r_t1 <= 34'(rp);
        end
        if (i_cmd.corr_latch) begin
            r_y   <= 33'(r_meas) - 33'(r_angle);
            r_p00 <= r_aa;
            r_p01 <= r_ab;
        end
        if (i_cmd.k0_latch) begin
            r_k0 <= div_q;
        end
        if (i_cmd.k1_latch) begin
            r_k1 <= div_q;
        end
        if (i_cmd.out_load) begin
            r_out.filtered_angle <= r_angle;
            r_out.bias_estimate  <= r_bias;
            r_out.unbiased_rate  <= r_rate;
        end
    end

    assign o_stat.div_done = div_done;
    assign o_out_data      = r_out;

endmodule

// ----- sv/kabf_ctrl.sv -----
// controller: sequences prediction, gain divides and correction for each word
module kabf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  kabf_pkg::t_stat i_stat,
    output kabf_pkg::t_cmd  o_cmd
);
    kabf_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kabf_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.mul   = kabf_pkg::M_NONE;
        o_cmd.wb    = kabf_pkg::W_NONE;
        case (r_state)
            kabf_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = kabf_pkg::ST_RATE;
                end
            end
            kabf_pkg::ST_RATE: begin
                o_cmd.mul = kabf_pkg::M_DT_RATE;
                n_state   = kabf_pkg::ST_BB;
            end
            kabf_pkg::ST_BB: begin
                o_cmd.wb  = kabf_pkg::W_ANGLE_DT;
                o_cmd.mul = kabf_pkg::M_DT_BB;
                n_state   = kabf_pkg::ST_QB;
            end
            kabf_pkg::ST_QB: begin
                o_cmd.wb  = kabf_pkg::W_T1;
                o_cmd.mul = kabf_pkg::M_QB_DT;
                n_state   = kabf_pkg::ST_INNER;
            end
            kabf_pkg::ST_INNER: begin
                o_cmd.wb  = kabf_pkg::W_BB_Q;
                o_cmd.mul = kabf_pkg::M_DT_INNER;
                n_state   = kabf_pkg::ST_AA;
            end
            kabf_pkg::ST_AA: begin
                o_cmd.wb = kabf_pkg::W_AA_PRED;
                n_state  = kabf_pkg::ST_DIV0_GO;
            end
            kabf_pkg::ST_DIV0_GO: begin
                o_cmd.div_start  = 1'b1;
                o_cmd.corr_latch = 1'b1;
                n_state          = kabf_pkg::ST_DIV0_WAIT;
            end
            kabf_pkg::ST_DIV0_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.k0_latch = 1'b1;
                    n_state        = kabf_pkg::ST_DIV1_GO;
                end
            end
            kabf_pkg::ST_DIV1_GO: begin
                o_cmd.div_start  = 1'b1;
                o_cmd.div_num_ba = 1'b1;
                n_state          = kabf_pkg::ST_DIV1_WAIT;
            end
            kabf_pkg::ST_DIV1_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.k1_latch = 1'b1;
                    n_state        = kabf_pkg::ST_C1;
                end
            end
            kabf_pkg::ST_C1: begin
                o_cmd.mul = kabf_pkg::M_K0_Y;
                n_state   = kabf_pkg::ST_C2;
            end
            kabf_pkg::ST_C2: begin
                o_cmd.wb  = kabf_pkg::W_ANGLE_K;
                o_cmd.mul = kabf_pkg::M_K1_Y;
                n_state   = kabf_pkg::ST_C3;
            end
            kabf_pkg::ST_C3: begin
                o_cmd.wb  = kabf_pkg::W_BIAS_K;
                o_cmd.mul = kabf_pkg::M_K0_P00;
                n_state   = kabf_pkg::ST_C4;
            end
            kabf_pkg::ST_C4: begin
                o_cmd.wb  = kabf_pkg::W_AA_K;
                o_cmd.mul = kabf_pkg::M_K0_P01;
                n_state   = kabf_pkg::ST_C5;
            end
            kabf_pkg::ST_C5: begin
                o_cmd.wb  = kabf_pkg::W_AB_K;
                o_cmd.mul = kabf_pkg::M_K1_P00;
                n_state   = kabf_pkg::ST_C6;
            end
            kabf_pkg::ST_C6: begin
                o_cmd.wb  = kabf_pkg::W_BA_K;
                o_cmd.mul = kabf_pkg::M_K1_P01;
                n_state   = kabf_pkg::ST_C7;
            end
            kabf_pkg::ST_C7: begin
                o_cmd.wb = kabf_pkg::W_BB_K;
                n_state  = kabf_pkg::ST_OUT;
            end
            kabf_pkg::ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = kabf_pkg::ST_IDLE;
                end
            end
            default: n_state = kabf_pkg::ST_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == kabf_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- sv/kabf_chk.sv -----
// port-level checks for the kalman filter unit and their binding
module kabf_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input kabf_pkg::t_out o_out_data
);
    // a held output word stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("output word dropped or changed while stalled");

    // one sample in flight: no acceptance on the cycle after one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second sample accepted while one is in work");

    // a fresh output word never follows an acceptance directly
    a_no_instant_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !$rose(o_out_valid))
        else $error("output word appeared without processing time");

    // hand-over of a word returns the block to the idle state
    a_idle_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("block not idle after delivering a word");

endmodule

bind kalman_angle_bias_filter_unit kabf_chk u_kabf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
